// ===== hdl/dfilt_pkg.sv =====
// dfilt_pkg: shared widths, config register indexes, task record and back-end state codes
// for the depth fringe filter; no dependencies
package dfilt_pkg;

    // field widths
    localparam int DEPTH_W = 16;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 10;
    localparam int FW_W    = 11;
    localparam int THR_W   = 16;

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRINGE_THRESHOLD = 2'd2;

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST      = 11'd640;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST     = 12'd480;
    localparam logic [THR_W-1:0] FRINGE_THRESHOLD_RST = 16'd100;

    // task queue between front and back
    localparam int TASK_DEPTH = 4;
    localparam int TASK_PTR_W = $clog2(TASK_DEPTH);
    localparam int TASK_CNT_W = $clog2(TASK_DEPTH + 1);

    // one pixel of the row above, with its raw 4-neighborhood
    typedef struct packed {
        logic [DEPTH_W-1:0] center;
        logic [DEPTH_W-1:0] up;
        logic [DEPTH_W-1:0] left;
        logic [DEPTH_W-1:0] right;
        logic [DEPTH_W-1:0] down;
        logic [ROW_W-1:0]   row;       // row of the input pixel (below the center)
        logic [COL_W-1:0]   col;
        logic               border;
        logic               last_row;
    } task_t;

    // back end emit phase
    typedef enum logic [1:0] {
        ST_ABOVE = 2'b01,
        ST_SELF  = 2'b10
    } back_state_t;

endpackage

// ===== hdl/dfilt_ram.sv =====
// dfilt_ram: generic single write port, single read port RAM with registered read
// no dependencies; read returns the old word on a same-address write
module dfilt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/dfilt_queue.sv =====
// dfilt_queue: small register FIFO of task records between front and back
// depends on dfilt_pkg
module dfilt_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  dfilt_pkg::task_t                 wr_task,
    input  logic                             rd_en,
    output dfilt_pkg::task_t                 rd_task,
    output logic                             rd_valid,
    output logic [dfilt_pkg::TASK_CNT_W-1:0] count
);

    import dfilt_pkg::*;

    task_t                 slot_reg [TASK_DEPTH];
    logic [TASK_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [TASK_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [TASK_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + TASK_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + TASK_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + TASK_CNT_W'(wr_en) - TASK_CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_task;
        end
    end

    assign rd_task  = slot_reg[rd_ptr_reg];
    assign rd_valid = (count_reg != '0);
    assign count    = count_reg;

endmodule

// ===== hdl/dfilt_front.sv =====
// dfilt_front: input acceptance, raster position, line buffers and neighborhood gathering
// depends on dfilt_pkg and dfilt_ram
module dfilt_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [dfilt_pkg::DEPTH_W-1:0]    depth_mm,
    input  logic [dfilt_pkg::FW_W-1:0]       frame_width,
    input  logic [dfilt_pkg::ROW_W-1:0]      frame_height,
    input  logic [dfilt_pkg::TASK_CNT_W-1:0] q_count,
    output logic                             q_push,
    output dfilt_pkg::task_t                 q_task
);

    import dfilt_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic            accept;
    logic [CW-1:0]   w_last;
    logic [ROW_W-1:0] h_last;
    logic [CW-1:0]   col;
    logic [ROW_W-1:0] row;
    logic            last_col;
    logic            last_row;

    logic [CW-1:0]    col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [DEPTH_W-1:0] left_reg, left_next;

    // item in flight while line buffer reads complete
    logic               s1_valid_reg;
    logic               s1_has_task_reg;
    logic [DEPTH_W-1:0] s1_down_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [CW-1:0]      s1_col_reg;
    logic               s1_border_reg;
    logic               s1_last_row_reg;
    logic               s1_last_col_reg;
    logic               s1_pending;

    logic [DEPTH_W-1:0] center_q;
    logic [DEPTH_W-1:0] right_q;
    logic [DEPTH_W-1:0] up_q;

    // effective geometry
    always_comb
    begin
        if (frame_width < 11'd3)
        begin
            w_last = CW'(2);
        end
        else if (32'(frame_width) > 32'(MAX_WIDTH))
        begin
            w_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = CW'(frame_width - 11'd1);
        end
        h_last = (frame_height < 12'd3) ? 12'd2 : frame_height - 12'd1;
    end

    // clamped position of the incoming pixel
    always_comb
    begin
        col      = (col_count_reg >= w_last) ? w_last : col_count_reg;
        row      = (row_count_reg >= h_last) ? h_last : row_count_reg;
        last_col = (col == w_last);
        last_row = (row == h_last);
    end

    // room for the item now in flight plus one more
    assign s1_pending = s1_valid_reg && s1_has_task_reg;
    assign full = (({1'b0, q_count} + (TASK_CNT_W + 1)'(s1_pending))
                   >= (TASK_CNT_W + 1)'(TASK_DEPTH));
    assign accept = push && !full;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : row + 12'd1;
            end
            else
            begin
                col_count_next = col + CW'(1);
                row_count_next = row;
            end
        end
        left_next = left_reg;
        if (s1_valid_reg)
        begin
            left_next = s1_last_col_reg ? '0 : center_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            left_reg      <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            left_reg      <= left_next;
            s1_valid_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_has_task_reg <= (row != '0);
            s1_down_reg     <= depth_mm;
            s1_row_reg      <= row;
            s1_col_reg      <= col;
            s1_border_reg   <= (row == 12'd1) || (col == '0) || last_col;
            s1_last_row_reg <= last_row;
            s1_last_col_reg <= last_col;
        end
    end

    // row above, center tap
    dfilt_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above_c (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col),
        .wr_data (depth_mm),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (center_q)
    );

    // row above, replica for the right tap
    dfilt_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above_r (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col),
        .wr_data (depth_mm),
        .rd_en   (accept),
        .rd_addr (col + CW'(1)),
        .rd_data (right_q)
    );

    // row two above, written once the center is known
    dfilt_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (center_q),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (up_q)
    );

    always_comb
    begin
        q_push          = s1_pending;
        q_task.center   = center_q;
        q_task.up       = up_q;
        q_task.left     = left_reg;
        q_task.right    = s1_last_col_reg ? '0 : right_q;
        q_task.down     = s1_down_reg;
        q_task.row      = s1_row_reg;
        q_task.col      = COL_W'(s1_col_reg);
        q_task.border   = s1_border_reg;
        q_task.last_row = s1_last_row_reg;
    end

endmodule

// ===== hdl/dfilt_back.sv =====
// dfilt_back: fringe test and result emission into the output register
// depends on dfilt_pkg
module dfilt_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dfilt_pkg::THR_W-1:0]   fringe_threshold,
    input  dfilt_pkg::task_t              q_task,
    input  logic                          q_valid,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [dfilt_pkg::DEPTH_W-1:0] out_depth,
    output logic [dfilt_pkg::ROW_W-1:0]   out_row,
    output logic [dfilt_pkg::COL_W-1:0]   out_col,
    output logic                          out_last
);

    import dfilt_pkg::*;

    function automatic logic too_far(input logic [DEPTH_W-1:0] a,
                                     input logic [DEPTH_W-1:0] b,
                                     input logic [THR_W-1:0]   thr);
        logic [DEPTH_W-1:0] d;
        begin
            d = (a > b) ? a - b : b - a;
            return d > thr;
        end
    endfunction

    back_state_t state_reg, state_next;

    logic               out_valid_reg, out_valid_next;
    logic [DEPTH_W-1:0] out_depth_reg, out_depth_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic               out_last_reg, out_last_next;

    logic               load;
    logic               issue;
    logic               bad;
    logic [DEPTH_W-1:0] filtered;

    always_comb
    begin
        bad = (q_task.center == '0) || (q_task.up == '0) || (q_task.left == '0) ||
              (q_task.right == '0) || (q_task.down == '0) ||
              too_far(q_task.center, q_task.up, fringe_threshold) ||
              too_far(q_task.center, q_task.left, fringe_threshold) ||
              too_far(q_task.center, q_task.right, fringe_threshold) ||
              too_far(q_task.center, q_task.down, fringe_threshold);
        filtered = (!q_task.border && bad) ? '0 : q_task.center;
    end

    always_comb
    begin
        load  = !out_valid_reg || pop;
        issue = q_valid && load;

        state_next     = state_reg;
        q_pop          = 1'b0;
        out_depth_next = out_depth_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        out_valid_next = load ? issue : out_valid_reg;

        unique case (state_reg)
            ST_ABOVE:
            begin
                if (issue)
                begin
                    out_depth_next = filtered;
                    out_row_next   = q_task.row - 12'd1;
                    out_col_next   = q_task.col;
                    out_last_next  = !q_task.last_row;
                    if (q_task.last_row)
                    begin
                        state_next = ST_SELF;
                    end
                    else
                    begin
                        q_pop = 1'b1;
                    end
                end
            end
            ST_SELF:
            begin
                if (issue)
                begin
                    out_depth_next = q_task.down;
                    out_row_next   = q_task.row;
                    out_col_next   = q_task.col;
                    out_last_next  = 1'b1;
                    q_pop          = 1'b1;
                    state_next     = ST_ABOVE;
                end
            end
            default:
            begin
                state_next = ST_ABOVE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ABOVE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_depth_reg <= out_depth_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
    end

    assign empty     = !out_valid_reg;
    assign out_depth = out_depth_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hdl/depth_fringe_filter.sv =====
// depth_fringe_filter: top level of the streaming 4-neighbor depth fringe filter
// depends on dfilt_pkg, dfilt_front, dfilt_queue, dfilt_back (and dfilt_ram below front)
//
//   channel   | handshake              | transfer when        | payload
//   ----------+------------------------+----------------------+---------------------------------
//   input     | push / full            | push && !full        | depth_mm
//   result    | empty / pop            | pop && !empty        | out_depth, out_row, out_col,
//             |                        |                      | out_last
//   config    | cfg_wr_en              | cfg_wr_en            | cfg_index, cfg_wr_data
//
// one pixel is taken per cycle while full is low; pixels of the last row give two results and
// the single output register then sets the pace for those pixels
// a result reaches the output register from the pixel below it once that pixel transfers in
// (line buffer read and in-flight registers, then the task queue into the output register)
// reset clears the position counters, queue and output valid flag; line buffers are not
// cleared, every entry read is written first during row zero, so no clearing pass runs
// full rises when the four-entry task queue, counting the pixel still in flight, is full
module depth_fringe_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration writes
    input  logic                             cfg_wr_en,
    input  logic [dfilt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfilt_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // pixel input
    input  logic                             push,
    output logic                             full,
    input  logic [dfilt_pkg::DEPTH_W-1:0]    depth_mm,
    // results
    output logic                             empty,
    input  logic                             pop,
    output logic [dfilt_pkg::DEPTH_W-1:0]    out_depth,
    output logic [dfilt_pkg::ROW_W-1:0]      out_row,
    output logic [dfilt_pkg::COL_W-1:0]      out_col,
    output logic                             out_last
);

    import dfilt_pkg::*;

    // configuration registers
    logic [FW_W-1:0]  frame_width_reg;
    logic [ROW_W-1:0] frame_height_reg;
    logic [THR_W-1:0] fringe_threshold_reg;

    // front to queue
    logic                  q_push;
    task_t                 q_wr_task;
    logic [TASK_CNT_W-1:0] q_count;

    // queue to back
    task_t q_rd_task;
    logic  q_valid;
    logic  q_pop;

    // register writes, out-of-list indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg      <= FRAME_WIDTH_RST;
            frame_height_reg     <= FRAME_HEIGHT_RST;
            fringe_threshold_reg <= FRINGE_THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:      frame_width_reg      <= cfg_wr_data[FW_W-1:0];
                CFG_FRAME_HEIGHT:     frame_height_reg     <= cfg_wr_data[ROW_W-1:0];
                CFG_FRINGE_THRESHOLD: fringe_threshold_reg <= cfg_wr_data[THR_W-1:0];
                default:
                begin
                    frame_width_reg <= frame_width_reg;
                end
            endcase
        end
    end

    // front: position tracking, line buffers, neighborhood gather
    dfilt_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .depth_mm     (depth_mm),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_count      (q_count),
        .q_push       (q_push),
        .q_task       (q_wr_task)
    );

    // decoupling queue of pending neighborhoods
    dfilt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_task  (q_wr_task),
        .rd_en    (q_pop),
        .rd_task  (q_rd_task),
        .rd_valid (q_valid),
        .count    (q_count)
    );

    // back: fringe decision and result sequencing
    dfilt_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .fringe_threshold (fringe_threshold_reg),
        .q_task           (q_rd_task),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .empty            (empty),
        .pop              (pop),
        .out_depth        (out_depth),
        .out_row          (out_row),
        .out_col          (out_col),
        .out_last         (out_last)
    );

endmodule
